@@ src/clr_pkg.sv @@
// Shared types, constants and control bundles for the clipped line rasterizer.
`timescale 1ns / 1ps
package clr_pkg;

    // Image and coordinate geometry.
    localparam int MAX_DIM = 64;
    localparam int XY_W    = 6;
    localparam int DIM_W   = 7;
    localparam int IN_W    = 12;
    localparam int COLOR_W = 32;

    // Clip arithmetic: coordinates saturate to +-2^20.
    localparam int CRD_W   = 22;
    localparam int DIF_W   = 23;
    localparam int MAG_W   = 22;
    localparam int PRD_W   = 44;
    localparam int SUM_W   = 46;
    localparam int DCNT_W  = 6;
    localparam int OFF_W   = 10;

    localparam logic signed [SUM_W-1:0] CLIP_HI = 46'sd1048576;
    localparam logic signed [SUM_W-1:0] CLIP_LO = -46'sd1048576;

    // Register map.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERT,
        KIND_HORZ,
        KIND_GEN
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [IN_W-1:0]    fx;
        logic signed [IN_W-1:0]    fy;
        logic signed [IN_W-1:0]    tx;
        logic signed [IN_W-1:0]    ty;
        logic [COLOR_W-1:0]        color;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_APPLY,
        ST_PASS,
        ST_BSETUP,
        ST_DRAW
    } back_state_t;

    typedef struct packed {
        logic               start;
        logic [PRD_W-1:0]   dividend;
        logic [MAG_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [PRD_W-1:0]   quotient;
    } div_resp_t;

    // Clamp a dimension register to 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] v;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (r > DIM_W'(MAX_DIM)) begin
            v = DIM_W'(MAX_DIM);
        end else begin
            v = r;
        end
        return v;
    endfunction

endpackage

@@ src/clr_front.sv @@
// Front end: accepts line items, classifies them and holds one for the queue.
`timescale 1ns / 1ps
module clr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [79:0]                  s_tdata,
    input  logic [clr_pkg::DIM_W-1:0]    width_cfg,
    input  logic [clr_pkg::DIM_W-1:0]    height_cfg,
    input  logic                         q_full,
    output logic                         q_push,
    output clr_pkg::cmd_t                q_cmd
);

    logic          valid_reg;
    logic          valid_next;
    clr_pkg::cmd_t cmd_reg;
    clr_pkg::cmd_t cmd_next;
    logic          take;

    assign q_push   = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign q_cmd    = cmd_reg;

    // Unpack and classify the incoming item.
    always_comb begin
        cmd_next       = cmd_reg;
        cmd_next.fx    = s_tdata[11:0];
        cmd_next.fy    = s_tdata[23:12];
        cmd_next.tx    = s_tdata[35:24];
        cmd_next.ty    = s_tdata[47:36];
        cmd_next.color = s_tdata[79:48];
        cmd_next.w     = clr_pkg::eff_dim(width_cfg);
        cmd_next.h     = clr_pkg::eff_dim(height_cfg);
        if (s_tdata[11:0] == s_tdata[35:24]) begin
            cmd_next.kind = clr_pkg::KIND_VERT;
        end else if (s_tdata[23:12] == s_tdata[47:36]) begin
            cmd_next.kind = clr_pkg::KIND_HORZ;
        end else begin
            cmd_next.kind = clr_pkg::KIND_GEN;
        end
    end

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (q_push) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ src/clr_fifo.sv @@
// Two-entry command queue between the front end and the drawing back end.
`timescale 1ns / 1ps
module clr_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  clr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output clr_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    clr_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/clr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module clr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  clr_pkg::div_req_t  req,
    output clr_pkg::div_resp_t resp
);

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [clr_pkg::DCNT_W-1:0]  cnt_reg;
    logic [clr_pkg::DCNT_W-1:0]  cnt_next;
    logic [clr_pkg::PRD_W-1:0]   quo_reg;
    logic [clr_pkg::PRD_W-1:0]   quo_next;
    logic [clr_pkg::MAG_W:0]     rem_reg;
    logic [clr_pkg::MAG_W:0]     rem_next;
    logic [clr_pkg::MAG_W-1:0]   dsr_reg;
    logic [clr_pkg::MAG_W-1:0]   dsr_next;
    logic [clr_pkg::MAG_W:0]     trial;

    assign resp.busy     = busy_reg;
    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

    // One shift-and-subtract step per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[clr_pkg::MAG_W-1:0], quo_reg[clr_pkg::PRD_W-1]};
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[clr_pkg::PRD_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[clr_pkg::PRD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == clr_pkg::DCNT_W'(clr_pkg::PRD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

@@ src/clr_back.sv @@
// Back end: clips general lines, steps spans and Bresenham lines, drives pixels.
`timescale 1ns / 1ps
module clr_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  clr_pkg::cmd_t           q_head,
    output logic                    q_pop,
    output clr_pkg::div_req_t       div_req,
    input  clr_pkg::div_resp_t      div_resp,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [47:0]             m_tdata,
    output logic                    m_tlast
);

    localparam int CW = clr_pkg::CRD_W;
    localparam int DW = clr_pkg::DIF_W;
    localparam int MW = clr_pkg::MAG_W;
    localparam int XW = clr_pkg::XY_W;
    localparam int OW = clr_pkg::OFF_W;
    localparam int SW = clr_pkg::SUM_W;

    clr_pkg::back_state_t state_reg, state_next;
    clr_pkg::cmd_t        cmd_reg, cmd_next;

    logic signed [CW-1:0] p0x_reg, p0x_next, p0y_reg, p0y_next;
    logic signed [CW-1:0] p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic [1:0]           pass_reg, pass_next, step_reg, step_next;
    logic [MW-1:0]        opa_reg, opa_next, opb_reg, opb_next, dsr_reg, dsr_next;
    logic                 neg_reg, neg_next;
    logic [clr_pkg::PRD_W-1:0] prod_reg, prod_next;

    logic [XW-1:0]        i_reg, i_next, end_reg, end_next, p_reg, p_next;
    logic [XW-1:0]        dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic signed [OW-1:0] off_reg, off_next;
    logic                 steep_reg, steep_next, sneg_reg, sneg_next;

    logic                 ov_reg, ov_next, olast_reg, olast_next;
    logic [XW-1:0]        ox_reg, ox_next, oy_reg, oy_next;
    logic [clr_pkg::COLOR_W-1:0] ocol_reg, ocol_next;

    // Clip step operands.
    logic                 a_p1, axis_x, high, cond;
    logic signed [CW-1:0] ax, ay, bx, by, au, av, bu, bv, e_val;
    logic signed [DW-1:0] dv, de, du;
    logic signed [SW-1:0] qs, sum, sat;
    logic signed [CW-1:0] av_new;

    // Span and Bresenham setup operands.
    logic signed [clr_pkg::IN_W-1:0] sa, sb, sc, lo, hi;
    logic signed [clr_pkg::IN_W:0]   mlim, nlim, lo_c, hi_c;
    logic                 in_image;
    logic [XW-1:0]        x0, y0, x1, y1, adx, ady;
    logic                 steep_c, swap_c;
    logic [XW-1:0]        ms, me, ps, pe;
    logic                 out_free;

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {4'b0, ocol_reg, oy_reg, ox_reg};
    assign out_free = !ov_reg || m_tready;

    assign div_req.start    = (state_reg == clr_pkg::ST_DIV);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = dsr_reg;

    // Select the moving endpoint and the edge of the current clip step.
    always_comb begin
        a_p1   = pass_reg[0];
        axis_x = !step_reg[1];
        high   = step_reg[0];
        ax = a_p1 ? p1x_reg : p0x_reg;
        ay = a_p1 ? p1y_reg : p0y_reg;
        bx = a_p1 ? p0x_reg : p1x_reg;
        by = a_p1 ? p0y_reg : p1y_reg;
        au = axis_x ? ax : ay;
        av = axis_x ? ay : ax;
        bu = axis_x ? bx : by;
        bv = axis_x ? by : bx;
        if (!high) begin
            e_val = '0;
        end else if (axis_x) begin
            e_val = CW'(cmd_reg.w) - CW'(1);
        end else begin
            e_val = CW'(cmd_reg.h) - CW'(1);
        end
        cond = high ? ((au >= e_val) && (bu != au)) : ((au < 0) && (au != bu));
        dv = DW'(bv) - DW'(av);
        de = DW'(e_val) - DW'(au);
        du = DW'(bu) - DW'(au);
        qs  = neg_reg ? -$signed({2'b0, div_resp.quotient})
                      : $signed({2'b0, div_resp.quotient});
        sum = SW'(av) + qs;
        if (sum > clr_pkg::CLIP_HI) begin
            sat = clr_pkg::CLIP_HI;
        end else if (sum < clr_pkg::CLIP_LO) begin
            sat = clr_pkg::CLIP_LO;
        end else begin
            sat = sum;
        end
        av_new = sat[CW-1:0];
    end

    // Span limits for vertical and horizontal lines.
    always_comb begin
        if (cmd_reg.kind == clr_pkg::KIND_VERT) begin
            sa = cmd_reg.fy; sb = cmd_reg.ty; sc = cmd_reg.fx;
            mlim = $signed({6'b0, cmd_reg.h});
            nlim = $signed({6'b0, cmd_reg.w});
        end else begin
            sa = cmd_reg.fx; sb = cmd_reg.tx; sc = cmd_reg.fy;
            mlim = $signed({6'b0, cmd_reg.w});
            nlim = $signed({6'b0, cmd_reg.h});
        end
        lo = (sa < sb) ? sa : sb;
        hi = (sa < sb) ? sb : sa;
        lo_c = (lo < 0) ? '0 : (clr_pkg::IN_W + 1)'(lo);
        hi_c = ((clr_pkg::IN_W + 1)'(hi) >= mlim) ? mlim - (clr_pkg::IN_W + 1)'(1)
                                                  : (clr_pkg::IN_W + 1)'(hi);
    end

    // Bresenham setup from the clipped endpoints.
    always_comb begin
        in_image = (p0x_reg >= 0) && (p0x_reg < CW'(cmd_reg.w)) &&
                   (p1x_reg >= 0) && (p1x_reg < CW'(cmd_reg.w)) &&
                   (p0y_reg >= 0) && (p0y_reg < CW'(cmd_reg.h)) &&
                   (p1y_reg >= 0) && (p1y_reg < CW'(cmd_reg.h));
        x0 = p0x_reg[XW-1:0]; y0 = p0y_reg[XW-1:0];
        x1 = p1x_reg[XW-1:0]; y1 = p1y_reg[XW-1:0];
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep_c = (ady >= adx);
        if (steep_c) begin
            swap_c = (y0 > y1);
            ms = swap_c ? y1 : y0; me = swap_c ? y0 : y1;
            ps = swap_c ? x1 : x0; pe = swap_c ? x0 : x1;
        end else begin
            swap_c = (x0 > x1);
            ms = swap_c ? x1 : x0; me = swap_c ? x0 : x1;
            ps = swap_c ? y1 : y0; pe = swap_c ? y0 : y1;
        end
    end

    // Sequencer: fetch, span setup, clip passes, Bresenham stepping.
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        p0x_next = p0x_reg; p0y_next = p0y_reg;
        p1x_next = p1x_reg; p1y_next = p1y_reg;
        pass_next = pass_reg; step_next = step_reg;
        opa_next = opa_reg; opb_next = opb_reg; dsr_next = dsr_reg;
        neg_next = neg_reg; prod_next = prod_reg;
        i_next = i_reg; end_next = end_reg; p_next = p_reg;
        dmaj_next = dmaj_reg; dmin_next = dmin_reg; off_next = off_reg;
        steep_next = steep_reg; sneg_next = sneg_reg;
        ov_next = out_free ? 1'b0 : ov_reg;
        olast_next = olast_reg; ox_next = ox_reg; oy_next = oy_reg;
        ocol_next = ocol_reg;
        q_pop = 1'b0;
        case (state_reg)
            clr_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head;
                    p0x_next  = CW'(q_head.fx); p0y_next = CW'(q_head.fy);
                    p1x_next  = CW'(q_head.tx); p1y_next = CW'(q_head.ty);
                    pass_next = '0;
                    step_next = '0;
                    state_next = (q_head.kind == clr_pkg::KIND_GEN) ? clr_pkg::ST_CHECK
                                                                    : clr_pkg::ST_SPAN;
                end
            end
            clr_pkg::ST_SPAN: begin
                if ((sc < 0) || ((clr_pkg::IN_W + 1)'(sc) >= nlim) || (lo_c > hi_c)) begin
                    state_next = clr_pkg::ST_IDLE;
                end else begin
                    i_next     = lo_c[XW-1:0];
                    end_next   = hi_c[XW-1:0];
                    p_next     = sc[XW-1:0];
                    dmaj_next  = '0;
                    dmin_next  = '0;
                    off_next   = '0;
                    sneg_next  = 1'b0;
                    steep_next = (cmd_reg.kind == clr_pkg::KIND_VERT);
                    state_next = clr_pkg::ST_DRAW;
                end
            end
            clr_pkg::ST_CHECK: begin
                if (cond) begin
                    opa_next = dv[DW-1] ? MW'(-dv) : MW'(dv);
                    opb_next = de[DW-1] ? MW'(-de) : MW'(de);
                    dsr_next = du[DW-1] ? MW'(-du) : MW'(du);
                    neg_next = dv[DW-1] ^ de[DW-1] ^ du[DW-1];
                    state_next = clr_pkg::ST_MUL;
                end else if (step_reg == 2'd3) begin
                    state_next = clr_pkg::ST_PASS;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            clr_pkg::ST_MUL: begin
                prod_next  = opa_reg * opb_reg;
                state_next = clr_pkg::ST_DIV;
            end
            clr_pkg::ST_DIV: begin
                state_next = clr_pkg::ST_WAIT;
            end
            clr_pkg::ST_WAIT: begin
                if (div_resp.done) begin
                    state_next = clr_pkg::ST_APPLY;
                end
            end
            clr_pkg::ST_APPLY: begin
                if (a_p1) begin
                    p1x_next = axis_x ? e_val : av_new;
                    p1y_next = axis_x ? av_new : e_val;
                end else begin
                    p0x_next = axis_x ? e_val : av_new;
                    p0y_next = axis_x ? av_new : e_val;
                end
                if (step_reg == 2'd3) begin
                    state_next = clr_pkg::ST_PASS;
                end else begin
                    step_next  = step_reg + 2'd1;
                    state_next = clr_pkg::ST_CHECK;
                end
            end
            clr_pkg::ST_PASS: begin
                step_next = '0;
                if ((p0x_reg == p1x_reg) || (p0y_reg == p1y_reg)) begin
                    state_next = clr_pkg::ST_IDLE;
                end else if (pass_reg == 2'd3) begin
                    state_next = clr_pkg::ST_BSETUP;
                end else begin
                    pass_next  = pass_reg + 2'd1;
                    state_next = clr_pkg::ST_CHECK;
                end
            end
            clr_pkg::ST_BSETUP: begin
                if (!in_image) begin
                    state_next = clr_pkg::ST_IDLE;
                end else begin
                    steep_next = steep_c;
                    i_next     = ms;
                    end_next   = me;
                    p_next     = ps;
                    sneg_next  = (pe < ps);
                    dmaj_next  = me - ms;
                    dmin_next  = steep_c ? adx : ady;
                    off_next   = $signed({3'b0, (steep_c ? adx : ady), 1'b0})
                               - $signed({4'b0, me - ms});
                    state_next = clr_pkg::ST_DRAW;
                end
            end
            clr_pkg::ST_DRAW: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    ox_next    = steep_reg ? p_reg : i_reg;
                    oy_next    = steep_reg ? i_reg : p_reg;
                    ocol_next  = cmd_reg.color;
                    olast_next = (i_reg == end_reg);
                    if (i_reg == end_reg) begin
                        state_next = clr_pkg::ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                        if (off_reg > 0) begin
                            p_next   = sneg_reg ? p_reg - 1'b1 : p_reg + 1'b1;
                            off_next = off_reg - $signed({3'b0, dmaj_reg, 1'b0})
                                     + $signed({3'b0, dmin_reg, 1'b0});
                        end else begin
                            off_next = off_reg + $signed({3'b0, dmin_reg, 1'b0});
                        end
                    end
                end
            end
            default: begin
                state_next = clr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clr_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        p0x_reg <= p0x_next; p0y_reg <= p0y_next;
        p1x_reg <= p1x_next; p1y_reg <= p1y_next;
        pass_reg <= pass_next; step_reg <= step_next;
        opa_reg <= opa_next; opb_reg <= opb_next; dsr_reg <= dsr_next;
        neg_reg <= neg_next; prod_reg <= prod_next;
        i_reg <= i_next; end_reg <= end_next; p_reg <= p_next;
        dmaj_reg <= dmaj_next; dmin_reg <= dmin_next; off_reg <= off_next;
        steep_reg <= steep_next; sneg_reg <= sneg_next;
        olast_reg <= olast_next; ox_reg <= ox_next; oy_reg <= oy_next;
        ocol_reg <= ocol_next;
    end

endmodule

@@ src/clipped_line_rasterizer_unit.sv @@
// Top level of the clipped line rasterizer: registers, front end, queue, divider, back end.
`timescale 1ns / 1ps
// Each item is a line; the block emits its pixels in order, last one flagged.
// Vertical and horizontal lines pass through a span setup state and are then
// stepped at one pixel per cycle while the output is not stalled. Other lines
// run up to sixteen clip steps; each step that moves an endpoint runs one
// multiply and a bit-serial divide, and the clipped line is then stepped at
// one pixel per cycle while the output is not stalled. A two-entry queue lets
// up to three further items be accepted while a line is being drawn.
module clipped_line_rasterizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // start_x, start_y, end_x, end_y, line_color
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // pixel_x, pixel_y, pixel_color, zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [clr_pkg::DIM_W-1:0] width_reg, width_next;
    logic [clr_pkg::DIM_W-1:0] height_reg, height_next;
    logic                      cfg_wr;
    logic                      q_push, q_pop, q_full, q_empty;
    clr_pkg::cmd_t             q_in, q_head;
    clr_pkg::div_req_t         div_req;
    clr_pkg::div_resp_t        div_resp;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == clr_pkg::REG_HEIGHT) ? {25'b0, height_reg}
                                                      : {25'b0, width_reg};

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr && (paddr[2] == clr_pkg::REG_WIDTH)) begin
            width_next = pwdata[clr_pkg::DIM_W-1:0];
        end
        if (cfg_wr && (paddr[2] == clr_pkg::REG_HEIGHT)) begin
            height_next = pwdata[clr_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= clr_pkg::DIM_W'(clr_pkg::MAX_DIM);
            height_reg <= clr_pkg::DIM_W'(clr_pkg::MAX_DIM);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    clr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in)
    );

    clr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    clr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    clr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_resp (div_resp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The front end never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The back end never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    // A division is only started while the divider is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_resp.busy)
        else $error("divider started while busy");

    // A started division is under way in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> div_resp.busy)
        else $error("divider did not start");

endmodule
